// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdf_pkg.sv =====
// Package with the codes and constants of the packet deframer.
package pdf_pkg;

    localparam logic [7:0] START_BYTE        = 8'hD5;
    localparam logic [7:0] END_BYTE          = 8'hEB;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

endpackage

// ===== rtl/packet_deframer_unit.sv =====
// Top level of the packet deframer: header capture, payload delivery and end-mark check.
//
//  Channel  Signals                       Direction  Payload
//  in       in_valid / in_ready           into       rx_byte
//  out      out_valid / out_ready         out of     kind, frame_opcode, frame_unit,
//                                                    data_byte, data_index, frame_length
//  cfg      cfg_valid / cfg_ready         into       cfg_data (max_payload)
//
// One received byte is taken per cycle unless the input is held off; its result, if any,
// appears in the output register in the cycle after the request is accepted.
// The input is held off only while a result sits in the output register and the
// consumer is not taking it in the same cycle.
// Reset returns the parser to hunting for the start byte and sets max_payload to 255.
// Configuration writes are always accepted.
module packet_deframer_unit
    import pdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] frame_opcode,
    output logic [7:0] frame_unit,
    output logic [7:0] data_byte,
    output logic [7:0] data_index,
    output logic [7:0] frame_length,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    // Parser phases. Codes six and seven are never entered but behave as hunting.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_UNIT    = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_END     = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] max_payload_reg;
    logic [7:0] held_opcode_reg, held_opcode_next;
    logic [7:0] held_unit_reg, held_unit_next;
    logic [7:0] declared_length_reg, declared_length_next;
    logic [7:0] payload_count_reg, payload_count_next;

    logic       out_valid_reg;
    kind_t      kind_reg;
    logic [7:0] frame_opcode_reg, frame_unit_reg, data_byte_reg;
    logic [7:0] data_index_reg, frame_length_reg;

    logic       in_fire;
    logic       emit;
    kind_t      res_kind;
    logic [7:0] res_data;
    logic [7:0] res_index;
    logic [7:0] reported_length;
    logic [8:0] count_inc;

    // A new byte may enter whenever the output register is empty or is being emptied.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // The reported length is truncated to max_payload unless that is zero.
    assign reported_length = ((max_payload_reg != 8'd0) && (declared_length_reg > max_payload_reg))
                           ? max_payload_reg : declared_length_reg;
    assign count_inc = {1'b0, payload_count_reg} + 9'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        held_opcode_next     = held_opcode_reg;
        held_unit_next       = held_unit_reg;
        declared_length_next = declared_length_reg;
        payload_count_next   = payload_count_reg;
        emit                 = 1'b0;
        res_kind             = KIND_DATA;
        res_data             = 8'd0;
        res_index            = 8'd0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_OPCODE:
                begin
                    held_opcode_next = rx_byte;
                    phase_next       = PH_UNIT;
                end
                PH_UNIT:
                begin
                    held_unit_next = rx_byte;
                    phase_next     = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    declared_length_next = rx_byte;
                    payload_count_next   = 8'd0;
                    // An empty payload goes straight to the end mark.
                    phase_next = (rx_byte == 8'd0) ? PH_END : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // Bytes beyond max_payload are drained without a result.
                    if (payload_count_reg < max_payload_reg)
                    begin
                        emit      = 1'b1;
                        res_kind  = KIND_DATA;
                        res_data  = rx_byte;
                        res_index = payload_count_reg;
                    end
                    payload_count_next = count_inc[7:0];
                    if (count_inc >= {1'b0, declared_length_reg})
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    // The byte is consumed whatever it holds, even a start byte.
                    emit       = 1'b1;
                    res_kind   = (rx_byte == END_BYTE) ? KIND_GOOD : KIND_BAD;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (rx_byte == START_BYTE) ? PH_OPCODE : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            max_payload_reg     <= MAX_PAYLOAD_RESET;
            held_opcode_reg     <= 8'd0;
            held_unit_reg       <= 8'd0;
            declared_length_reg <= 8'd0;
            payload_count_reg   <= 8'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            held_opcode_reg     <= held_opcode_next;
            held_unit_reg       <= held_unit_next;
            declared_length_reg <= declared_length_next;
            payload_count_reg   <= payload_count_next;
            if (cfg_valid && cfg_ready)
            begin
                max_payload_reg <= cfg_data;
            end
            if (in_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            kind_reg         <= res_kind;
            frame_opcode_reg <= held_opcode_reg;
            frame_unit_reg   <= held_unit_reg;
            data_byte_reg    <= res_data;
            data_index_reg   <= res_index;
            frame_length_reg <= reported_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign frame_opcode = frame_opcode_reg;
    assign frame_unit   = frame_unit_reg;
    assign data_byte    = data_byte_reg;
    assign data_index   = data_index_reg;
    assign frame_length = frame_length_reg;

endmodule

// ===== rtl/pdf_checker.sv =====
// Port-level checker of the packet deframer and its bind to the top level.
`include "assert_macros.svh"

module pdf_checker
    import pdf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] data_byte,
    input logic [7:0] data_index,
    input logic [7:0] frame_length
);

    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid,
                 "result dropped while stalled")
    `ASSERT_NEXT(a_result_needs_request, clk, rst_n, !out_valid && !(in_valid && in_ready),
                 !out_valid, "result appeared without an accepted request")
    `ASSERT_SAME(a_ready_only_on_backlog, clk, rst_n, !in_ready, out_valid && !out_ready,
                 "input held off without a waiting result")
    `ASSERT_SAME(a_end_fields_zero, clk, rst_n, out_valid && (kind != KIND_DATA),
                 (data_byte == 8'd0) && (data_index == 8'd0), "end result carries payload fields")
    `ASSERT_SAME(a_index_in_length, clk, rst_n, out_valid && (kind == KIND_DATA),
                 data_index < frame_length, "payload index beyond reported length")

endmodule

bind packet_deframer_unit pdf_checker u_pdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .data_index   (data_index),
    .frame_length (frame_length)
);
